// File: rtl/swrm_pkg.sv
package swrm_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 64;
    localparam logic [31:0] SPAN_RESET       = 32'd10000;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned ENTRY_W = STAMP_W + LEN_W;
    localparam int unsigned WCNT_W  = 7;
    localparam int unsigned WSUM_W  = 22;
    localparam int unsigned TOT_W   = 32;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TIME    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DROP,
        ST_PUSH,
        ST_PRUNE_RD,
        ST_PRUNE_CHK,
        ST_OUT
    } t_state;

endpackage

// File: rtl/swrm_in_if.sv
interface swrm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [swrm_pkg::STAMP_W-1:0]  time_stamp;
    logic [swrm_pkg::LEN_W-1:0]    msg_len;

    modport source (output valid, output command, output time_stamp, output msg_len,
                    input ready);
    modport sink   (input valid, input command, input time_stamp, input msg_len,
                    output ready);
endinterface

// File: rtl/swrm_out_if.sv
interface swrm_out_if;
    logic                        valid;
    logic                        ready;
    logic [swrm_pkg::WCNT_W-1:0] window_count;
    logic [swrm_pkg::WSUM_W-1:0] window_chars;
    logic [swrm_pkg::TOT_W-1:0]  total_count;
    logic [swrm_pkg::TOT_W-1:0]  char_total;
    logic                        overflow_flag;

    modport source (output valid, output window_count, output window_chars,
                    output total_count, output char_total, output overflow_flag,
                    input ready);
    modport sink   (input valid, input window_count, input window_chars,
                    input total_count, input char_total, input overflow_flag,
                    output ready);
endinterface

// File: rtl/swrm_cfg_if.sv
interface swrm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [swrm_pkg::TOT_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sliding_window_rate_meter_top.sv
// An item is accepted only in the idle state, so a further item waits until the result is taken.
// An arrival while the time is unset, or a time update to zero, goes straight to ST_OUT; other
// time updates pass through the prune states, and arrivals through ST_PUSH (after ST_DROP_RD and
// ST_DROP when the window is full) and then the prune states. Each expired entry removed is read
// in ST_PRUNE_RD and checked in ST_PRUNE_CHK by the single memory read port and shared subtractor.
// Synchronous active-low reset clears the counters, the current time and the window
// pointers, and sets the window span to 10000; the window memory itself is not cleared.
module sliding_window_rate_meter_top #(
    parameter int unsigned WINDOW_DEPTH = swrm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swrm_in_if.sink      i_in,
    swrm_out_if.source   o_res,
    swrm_cfg_if.sink     i_cfg
);

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SW = AW + 1;
    localparam int unsigned SPW = swrm_pkg::STAMP_W;
    localparam int unsigned LW = swrm_pkg::LEN_W;
    localparam int unsigned WSW = swrm_pkg::WSUM_W;
    localparam int unsigned TW = swrm_pkg::TOT_W;
    localparam int unsigned WCW = swrm_pkg::WCNT_W;

    swrm_pkg::t_state r_state, n_state;

    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [WSW-1:0] r_sum, n_sum;
    logic [SPW-1:0] r_cur, n_cur;
    logic [TW-1:0]  r_msgs, n_msgs;
    logic [TW-1:0]  r_chars, n_chars;
    logic [TW-1:0]  r_span;
    logic           r_ovf, n_ovf;
    logic           r_keep, n_keep;
    logic           r_cmd;
    logic [SPW-1:0] r_ts;
    logic [LW-1:0]  r_len;

    logic                         we;
    logic [AW-1:0]                tail;
    logic [SW-1:0]                tail_raw;
    logic [swrm_pkg::ENTRY_W-1:0] rd_data;
    logic [SPW-1:0]               rd_stamp;
    logic [LW-1:0]                rd_len;
    logic [SPW:0]                 age;
    logic                         expired;
    logic                         accept;
    logic [AW-1:0]                head_inc;

    swrm_ram #(
        .WIDTH (swrm_pkg::ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (tail),
        .i_wdata ({r_ts, r_len}),
        .i_raddr (r_head),
        .o_rdata (rd_data)
    );

    assign rd_stamp = rd_data[swrm_pkg::ENTRY_W-1:LW];
    assign rd_len   = rd_data[LW-1:0];

    // The shared subtractor yields the age of the oldest entry and its borrow.
    assign age     = {1'b0, r_cur} - {1'b0, rd_stamp};
    assign expired = !age[SPW] && (age[SPW-1:0] != '0) && (age[SPW-1:0] > r_span);

    assign tail_raw = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_raw >= SW'(WINDOW_DEPTH)) ? AW'(tail_raw - SW'(WINDOW_DEPTH))
                                                      : AW'(tail_raw);
    assign head_inc = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);

    assign i_in.ready  = (r_state == swrm_pkg::ST_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid         = (r_state == swrm_pkg::ST_OUT);
    assign o_res.window_count  = WCW'(r_count);
    assign o_res.window_chars  = r_sum;
    assign o_res.total_count   = r_msgs;
    assign o_res.char_total    = r_chars;
    assign o_res.overflow_flag = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swrm_pkg::ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_cur   <= '0;
            r_msgs  <= '0;
            r_chars <= '0;
            r_ovf   <= 1'b0;
            r_keep  <= 1'b0;
            r_span  <= swrm_pkg::SPAN_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_cur   <= n_cur;
            r_msgs  <= n_msgs;
            r_chars <= n_chars;
            r_ovf   <= n_ovf;
            r_keep  <= n_keep;
            if (i_cfg.valid && i_cfg.ready && (i_cfg.data != '0)) begin
                r_span <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in.command;
            r_ts  <= i_in.time_stamp;
            r_len <= i_in.msg_len;
        end
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_sum   = r_sum;
        n_cur   = r_cur;
        n_msgs  = r_msgs;
        n_chars = r_chars;
        n_ovf   = r_ovf;
        n_keep  = r_keep;
        we      = 1'b0;
        unique case (r_state)
            swrm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_ovf = 1'b0;
                    if (i_in.command == swrm_pkg::CMD_ARRIVAL) begin
                        n_msgs  = r_msgs + TW'(1);
                        n_chars = r_chars + TW'(i_in.msg_len);
                        n_keep  = 1'b1;
                        if (r_cur == '0) begin
                            n_state = swrm_pkg::ST_OUT;
                        end else if (r_count == CW'(WINDOW_DEPTH)) begin
                            n_state = swrm_pkg::ST_DROP_RD;
                        end else begin
                            n_state = swrm_pkg::ST_PUSH;
                        end
                    end else begin
                        n_cur  = i_in.time_stamp;
                        n_keep = 1'b0;
                        if (i_in.time_stamp == '0) begin
                            n_state = swrm_pkg::ST_OUT;
                        end else begin
                            n_state = swrm_pkg::ST_PRUNE_RD;
                        end
                    end
                end
            end
            swrm_pkg::ST_DROP_RD: begin
                n_state = swrm_pkg::ST_DROP;
            end
            swrm_pkg::ST_DROP: begin
                n_sum   = r_sum - WSW'(rd_len);
                n_head  = head_inc;
                n_count = r_count - CW'(1);
                n_ovf   = 1'b1;
                n_state = swrm_pkg::ST_PUSH;
            end
            swrm_pkg::ST_PUSH: begin
                we      = 1'b1;
                n_count = r_count + CW'(1);
                n_sum   = r_sum + WSW'(r_len);
                n_state = swrm_pkg::ST_PRUNE_RD;
            end
            swrm_pkg::ST_PRUNE_RD: begin
                if (r_count > CW'(r_keep)) begin
                    n_state = swrm_pkg::ST_PRUNE_CHK;
                end else begin
                    n_state = swrm_pkg::ST_OUT;
                end
            end
            swrm_pkg::ST_PRUNE_CHK: begin
                if (expired) begin
                    n_sum   = r_sum - WSW'(rd_len);
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                    n_state = swrm_pkg::ST_PRUNE_RD;
                end else begin
                    n_state = swrm_pkg::ST_OUT;
                end
            end
            swrm_pkg::ST_OUT: begin
                if (o_res.ready) begin
                    n_state = swrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swrm_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW_DEPTH))
        else $error("window count exceeds the store depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_res.valid))
        else $error("input ready while a result is pending");

    a_ovf_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.overflow_flag) |-> (r_cmd == swrm_pkg::CMD_ARRIVAL))
        else $error("overflow flag set for a time update");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swrm_pkg::ST_PUSH) |-> (r_count < CW'(WINDOW_DEPTH)))
        else $error("push into a full window store");
`endif

endmodule

// File: rtl/swrm_ram.sv
module swrm_ram #(
    parameter int unsigned WIDTH = swrm_pkg::ENTRY_W,
    parameter int unsigned DEPTH = swrm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
